// ----- rtl/core/wsdf_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by the channel interfaces and the top level.
package wsdf_pkg;

    // Widths of the beat fields
    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int OFFSET_W = 63;
    localparam int ERR_W    = 3;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [ERR_W-1:0]    err_t;

    // Protocol error codes
    localparam err_t ERR_NONE        = 3'd0;
    localparam err_t ERR_RESERVED    = 3'd1;
    localparam err_t ERR_CTRL_FRAG   = 3'd2;
    localparam err_t ERR_DANGLING    = 3'd3;
    localparam err_t ERR_MISSING     = 3'd4;
    localparam err_t ERR_UNMASKED    = 3'd5;
    localparam err_t ERR_CTRL_LARGE  = 3'd6;

    // Header constants
    localparam byte_t   FIN_BIT       = 8'h80;
    localparam byte_t   RSV_BITS      = 8'h70;
    localparam byte_t   LEN7_MASK     = 8'h7F;
    localparam byte_t   LEN7_EXT16    = 8'h7E;
    localparam opcode_t OPC_CONT      = 4'h0;
    localparam offset_t OFFSET_MAX    = {OFFSET_W{1'b1}};

endpackage

// ----- rtl/core/wsdf_in_if.sv -----
// Input channel: one raw stream byte per beat, valid/ready handshake.
// Depends on wsdf_pkg.
interface wsdf_in_if;
    logic             valid;
    logic             ready;
    wsdf_pkg::byte_t  stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// ----- rtl/core/wsdf_out_if.sv -----
// Output channel: one parse result per beat, valid/ready handshake.
// Depends on wsdf_pkg.
interface wsdf_out_if;
    logic               valid;
    logic               ready;
    logic               frame_start;
    wsdf_pkg::opcode_t  frame_opcode;
    logic               payload_valid;
    wsdf_pkg::byte_t    payload_byte;
    logic               is_control;
    wsdf_pkg::offset_t  payload_offset;
    logic               message_end;
    logic               control_end;
    wsdf_pkg::offset_t  message_length;
    wsdf_pkg::err_t     error_code;

    modport source (output valid, output frame_start, output frame_opcode,
                    output payload_valid, output payload_byte, output is_control,
                    output payload_offset, output message_end, output control_end,
                    output message_length, output error_code, input ready);
    modport sink   (input valid, input frame_start, input frame_opcode,
                    input payload_valid, input payload_byte, input is_control,
                    input payload_offset, input message_end, input control_end,
                    input message_length, input error_code, output ready);
endinterface

// ----- rtl/core/websocket_frame_deframer.sv -----
// WebSocket frame deframer top level: header parser, unmasking and result register.
// Depends on wsdf_pkg, wsdf_in_if and wsdf_out_if.
//
// Usage:
//   stream carries the encoded byte stream, one byte per beat. Every accepted
//   byte yields exactly one beat on result: header bytes show the opcode being
//   parsed, payload bytes come out unmasked with their offset in the data
//   message (or in the control frame), and frame start, message end (with the
//   total length) and control frame end are flagged on the byte that causes them.
//   A byte accepted from stream is held in the result register and is on result in the next cycle.
//   Throughput is one byte per cycle while the receiver takes each result; the
//   parse state is updated in the same cycle that the byte is taken, and the single
//   result register is refilled in the cycle it is drained.
//   When the receiver stalls, the result register holds and stream.ready drops
//   until the result is taken; no byte is lost.
//   Write require_masked via cfg_we/cfg_wdata only while idle; the block does not check.
//   Reset clears the parser to expect an opcode byte, clears require_masked,
//   and clears the sticky error; after a protocol error every later byte
//   returns only the error code until reset.
module websocket_frame_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    wsdf_in_if.sink           stream,
    wsdf_out_if.source        result
);

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEN,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_DATA,
        PH_CTRL,
        PH_HALT
    } phase_t;

    // Parse state
    phase_t              phase_reg, phase_next;
    logic [2:0]          hdr_cnt_reg, hdr_cnt_next;
    wsdf_pkg::opcode_t   opcode_reg, opcode_next;
    logic                fin_reg, fin_next;
    logic                masked_reg, masked_next;
    wsdf_pkg::offset_t   flen_reg, flen_next;
    wsdf_pkg::offset_t   fpos_reg, fpos_next;
    logic [31:0]         key_reg, key_next;
    wsdf_pkg::offset_t   mpos_reg, mpos_next;
    logic                prev_final_reg, prev_final_next;
    wsdf_pkg::err_t      err_reg, err_next;
    logic                req_mask_reg;

    // Result register
    logic                out_valid_reg;
    logic                r_start_reg, r_start_next;
    wsdf_pkg::opcode_t   r_opc_reg, r_opc_next;
    logic                r_pvalid_reg, r_pvalid_next;
    wsdf_pkg::byte_t     r_pbyte_reg, r_pbyte_next;
    logic                r_ctrl_reg, r_ctrl_next;
    wsdf_pkg::offset_t   r_poff_reg, r_poff_next;
    logic                r_mend_reg, r_mend_next;
    logic                r_cend_reg, r_cend_next;
    wsdf_pkg::offset_t   r_mlen_reg, r_mlen_next;
    wsdf_pkg::err_t      r_err_reg, r_err_next;

    logic                in_fire;
    wsdf_pkg::byte_t     b;

    assign stream.ready = !out_valid_reg || result.ready;
    assign in_fire      = stream.valid && stream.ready;
    assign b            = stream.stream_byte;

    // Parse one byte: next state and result fields
    always_comb
    begin
        logic                fail;
        wsdf_pkg::err_t      fail_code;
        logic                len_done;
        logic                hdr_done;
        logic                frm_end;
        wsdf_pkg::opcode_t   opc_in;
        wsdf_pkg::byte_t     key_byte;
        wsdf_pkg::byte_t     len7;

        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        opcode_next     = opcode_reg;
        fin_next        = fin_reg;
        masked_next     = masked_reg;
        flen_next       = flen_reg;
        fpos_next       = fpos_reg;
        key_next        = key_reg;
        mpos_next       = mpos_reg;
        prev_final_next = prev_final_reg;
        err_next        = err_reg;

        r_start_next  = 1'b0;
        r_opc_next    = opcode_reg;
        r_pvalid_next = 1'b0;
        r_pbyte_next  = '0;
        r_ctrl_next   = opcode_reg[3];
        r_poff_next   = '0;
        r_mend_next   = 1'b0;
        r_cend_next   = 1'b0;
        r_mlen_next   = '0;
        r_err_next    = wsdf_pkg::ERR_NONE;

        fail      = 1'b0;
        fail_code = wsdf_pkg::ERR_NONE;
        len_done  = 1'b0;
        hdr_done  = 1'b0;
        frm_end   = 1'b0;
        opc_in    = b[3:0];
        key_byte  = '0;
        len7      = b & wsdf_pkg::LEN7_MASK;

        if (err_reg != wsdf_pkg::ERR_NONE || phase_reg == PH_HALT)
        begin
            r_opc_next  = '0;
            r_ctrl_next = 1'b0;
            r_err_next  = err_reg;
        end
        else
        begin
            case (phase_reg)
                PH_OPCODE:
                begin
                    if ((b & wsdf_pkg::RSV_BITS) != '0)
                    begin
                        fail      = 1'b1;
                        fail_code = wsdf_pkg::ERR_RESERVED;
                    end
                    else if (opc_in[3] && (b & wsdf_pkg::FIN_BIT) == '0)
                    begin
                        fail      = 1'b1;
                        fail_code = wsdf_pkg::ERR_CTRL_FRAG;
                    end
                    else if (opc_in == wsdf_pkg::OPC_CONT && prev_final_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = wsdf_pkg::ERR_DANGLING;
                    end
                    else if (opc_in != wsdf_pkg::OPC_CONT && !opc_in[3] && !prev_final_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = wsdf_pkg::ERR_MISSING;
                    end
                    else
                    begin
                        opcode_next  = opc_in;
                        fin_next     = b[7];
                        masked_next  = 1'b0;
                        flen_next    = '0;
                        fpos_next    = '0;
                        key_next     = '0;
                        hdr_cnt_next = '0;
                        phase_next   = PH_LEN;
                        r_opc_next   = opc_in;
                        r_ctrl_next  = opc_in[3];
                    end
                end

                PH_LEN:
                begin
                    masked_next = b[7];
                    if (req_mask_reg && !b[7])
                    begin
                        fail      = 1'b1;
                        fail_code = wsdf_pkg::ERR_UNMASKED;
                    end
                    else
                    begin
                        flen_next    = {{(wsdf_pkg::OFFSET_W-8){1'b0}}, len7};
                        hdr_cnt_next = '0;
                        if (len7 >= wsdf_pkg::LEN7_EXT16)
                        begin
                            if (opcode_reg[3])
                            begin
                                fail      = 1'b1;
                                fail_code = wsdf_pkg::ERR_CTRL_LARGE;
                            end
                            else
                            begin
                                flen_next  = '0;
                                phase_next = (len7 == wsdf_pkg::LEN7_EXT16) ? PH_EXT16
                                                                             : PH_EXT64;
                            end
                        end
                        else
                        begin
                            len_done = 1'b1;
                        end
                    end
                end

                PH_EXT16, PH_EXT64:
                begin
                    // shift in big-endian length; the 63-bit register drops the top bit
                    flen_next    = {flen_reg[wsdf_pkg::OFFSET_W-9:0], b};
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (phase_reg == PH_EXT16 && hdr_cnt_next == 3'd2)
                    begin
                        len_done = 1'b1;
                    end
                    else if (phase_reg == PH_EXT64 && hdr_cnt_next == 3'd0)
                    begin
                        len_done = 1'b1;
                    end
                end

                PH_MASK:
                begin
                    // collect key bytes, first byte in the low lane
                    case (hdr_cnt_reg[1:0])
                        2'd0:    key_next[7:0]   = key_reg[7:0]   | b;
                        2'd1:    key_next[15:8]  = key_reg[15:8]  | b;
                        2'd2:    key_next[23:16] = key_reg[23:16] | b;
                        default: key_next[31:24] = key_reg[31:24] | b;
                    endcase
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_next[2])
                    begin
                        hdr_cnt_next = '0;
                        hdr_done     = 1'b1;
                    end
                end

                PH_DATA, PH_CTRL:
                begin
                    case (fpos_reg[1:0])
                        2'd0:    key_byte = key_reg[7:0];
                        2'd1:    key_byte = key_reg[15:8];
                        2'd2:    key_byte = key_reg[23:16];
                        default: key_byte = key_reg[31:24];
                    endcase
                    r_pvalid_next = 1'b1;
                    r_pbyte_next  = b ^ key_byte;
                    if (phase_reg == PH_DATA)
                    begin
                        r_poff_next = mpos_reg;
                        if (mpos_reg != wsdf_pkg::OFFSET_MAX)
                        begin
                            mpos_next = mpos_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        r_poff_next = fpos_reg;
                    end
                    fpos_next = fpos_reg + 1'b1;
                    if (fpos_next >= flen_reg)
                    begin
                        frm_end = 1'b1;
                    end
                end

                default:
                begin
                    phase_next = PH_OPCODE;
                end
            endcase

            // Length complete: go for the key or finish the header
            if (len_done)
            begin
                hdr_cnt_next = '0;
                if (masked_next)
                begin
                    phase_next = PH_MASK;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            // Header complete: flag start, enter payload or end an empty frame
            if (hdr_done)
            begin
                r_start_next = (opcode_reg != wsdf_pkg::OPC_CONT);
                fpos_next    = '0;
                if (flen_next == '0)
                begin
                    frm_end = 1'b1;
                end
                else
                begin
                    phase_next = opcode_reg[3] ? PH_CTRL : PH_DATA;
                end
            end

            // Frame end: close the control frame or the data fragment
            if (frm_end)
            begin
                if (opcode_reg[3])
                begin
                    r_cend_next = 1'b1;
                end
                else if (fin_reg)
                begin
                    r_mend_next     = 1'b1;
                    r_mlen_next     = mpos_next;
                    mpos_next       = '0;
                    prev_final_next = 1'b1;
                end
                else
                begin
                    prev_final_next = 1'b0;
                end
                phase_next = PH_OPCODE;
            end

            // Protocol error: halt and report only the code
            if (fail)
            begin
                err_next      = fail_code;
                phase_next    = PH_HALT;
                r_start_next  = 1'b0;
                r_opc_next    = '0;
                r_pvalid_next = 1'b0;
                r_pbyte_next  = '0;
                r_ctrl_next   = 1'b0;
                r_poff_next   = '0;
                r_mend_next   = 1'b0;
                r_cend_next   = 1'b0;
                r_mlen_next   = '0;
                r_err_next    = fail_code;
            end
        end
    end

    // Hold parse state; advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPCODE;
            hdr_cnt_reg    <= '0;
            opcode_reg     <= '0;
            fin_reg        <= 1'b0;
            masked_reg     <= 1'b0;
            flen_reg       <= '0;
            fpos_reg       <= '0;
            key_reg        <= '0;
            mpos_reg       <= '0;
            prev_final_reg <= 1'b1;
            err_reg        <= wsdf_pkg::ERR_NONE;
            req_mask_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                req_mask_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                phase_reg      <= phase_next;
                hdr_cnt_reg    <= hdr_cnt_next;
                opcode_reg     <= opcode_next;
                fin_reg        <= fin_next;
                masked_reg     <= masked_next;
                flen_reg       <= flen_next;
                fpos_reg       <= fpos_next;
                key_reg        <= key_next;
                mpos_reg       <= mpos_next;
                prev_final_reg <= prev_final_next;
                err_reg        <= err_next;
            end
        end
    end

    // Result valid: set on accept, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load result fields on accept
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            r_start_reg  <= r_start_next;
            r_opc_reg    <= r_opc_next;
            r_pvalid_reg <= r_pvalid_next;
            r_pbyte_reg  <= r_pbyte_next;
            r_ctrl_reg   <= r_ctrl_next;
            r_poff_reg   <= r_poff_next;
            r_mend_reg   <= r_mend_next;
            r_cend_reg   <= r_cend_next;
            r_mlen_reg   <= r_mlen_next;
            r_err_reg    <= r_err_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.frame_start    = r_start_reg;
    assign result.frame_opcode   = r_opc_reg;
    assign result.payload_valid  = r_pvalid_reg;
    assign result.payload_byte   = r_pbyte_reg;
    assign result.is_control     = r_ctrl_reg;
    assign result.payload_offset = r_poff_reg;
    assign result.message_end    = r_mend_reg;
    assign result.control_end    = r_cend_reg;
    assign result.message_length = r_mlen_reg;
    assign result.error_code     = r_err_reg;

endmodule
